// ===== sv/wsfd_pkg.sv =====
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_LEN64   = 2'd2,
    KIND_OVERLIM = 2'd3
  } kind_t;

  localparam logic [15:0] RESET_LIMIT = 16'd200;
  localparam logic [6:0]  LEN7_EXT16  = 7'd126;
  localparam logic [6:0]  LEN7_EXT64  = 7'd127;
  localparam logic [15:0] KEY_LAST    = 16'd3;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [6:0]  opcode;
    logic        last;
    logic [15:0] payload_length;
  } result_t;

endpackage

// ===== sv/wsfd_parser.sv =====
module wsfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       max_payload,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  frame_opcode_r, frame_opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;

  // length as known after this byte, for the header phases that complete it
  logic [15:0] new_len;
  logic [7:0]  key_byte;
  logic        is_last;

  always_comb begin
    if (phase_r == PH_LENLO) begin
      new_len = {frame_length_r[15:8], rx_byte};
    end else begin
      new_len = {9'd0, rx_byte[6:0]};
    end
    case (byte_count_r[1:0])
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
    is_last = ({1'b0, byte_count_r} + 17'd1) >= {1'b0, frame_length_r};
  end

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    frame_opcode_nxt = frame_opcode_r;
    masked_nxt       = masked_r;
    frame_length_nxt = frame_length_r;
    mask_key_nxt     = mask_key_r;
    byte_count_nxt   = byte_count_r;
    case (phase_r)
      PH_HDR1: begin
        masked_nxt = rx_byte[7];
        if (rx_byte[6:0] == LEN7_EXT64) begin
          phase_nxt = PH_HDR0;
        end else if (rx_byte[6:0] == LEN7_EXT16) begin
          phase_nxt = PH_LENHI;
        end else begin
          frame_length_nxt = new_len;
          if (new_len > max_payload) begin
            phase_nxt = PH_HDR0;
          end else begin
            byte_count_nxt = 16'd0;
            if (rx_byte[7]) begin
              mask_key_nxt = 32'd0;
              phase_nxt    = PH_KEY;
            end else if (new_len == 16'd0) begin
              phase_nxt = PH_HDR0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
      end
      PH_LENHI: begin
        frame_length_nxt = {rx_byte, 8'd0};
        phase_nxt        = PH_LENLO;
      end
      PH_LENLO: begin
        frame_length_nxt = new_len;
        if (new_len > max_payload) begin
          phase_nxt = PH_HDR0;
        end else begin
          byte_count_nxt = 16'd0;
          if (masked_r) begin
            mask_key_nxt = 32'd0;
            phase_nxt    = PH_KEY;
          end else if (new_len == 16'd0) begin
            phase_nxt = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_KEY: begin
        mask_key_nxt = {mask_key_r[23:0], rx_byte};
        if (byte_count_r == KEY_LAST) begin
          byte_count_nxt = 16'd0;
          phase_nxt      = (frame_length_r == 16'd0) ? PH_HDR0 : PH_DATA;
        end else begin
          byte_count_nxt = byte_count_r + 16'd1;
        end
      end
      PH_DATA: begin
        byte_count_nxt = byte_count_r + 16'd1;
        if (is_last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        frame_opcode_nxt = rx_byte[6:0];
        phase_nxt        = PH_HDR1;
      end
    endcase
  end

  // result for this byte
  always_comb begin
    res.valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = 8'd0;
    res.opcode         = frame_opcode_r;
    res.last           = 1'b1;
    res.payload_length = 16'd0;
    case (phase_r)
      PH_HDR1: begin
        if (rx_byte[6:0] == LEN7_EXT64) begin
          res.valid = 1'b1;
          res.kind  = KIND_LEN64;
        end else if (rx_byte[6:0] != LEN7_EXT16) begin
          if (new_len > max_payload) begin
            res.valid          = 1'b1;
            res.kind           = KIND_OVERLIM;
            res.payload_length = new_len;
          end else if (!rx_byte[7] && new_len == 16'd0) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end
        end
      end
      PH_LENLO: begin
        if (new_len > max_payload) begin
          res.valid          = 1'b1;
          res.kind           = KIND_OVERLIM;
          res.payload_length = new_len;
        end else if (!masked_r && new_len == 16'd0) begin
          res.valid = 1'b1;
          res.kind  = KIND_EMPTY;
        end
      end
      PH_KEY: begin
        if (byte_count_r == KEY_LAST && frame_length_r == 16'd0) begin
          res.valid = 1'b1;
          res.kind  = KIND_EMPTY;
        end
      end
      PH_DATA: begin
        res.valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.data_byte      = masked_r ? (rx_byte ^ key_byte) : rx_byte;
        res.last           = is_last;
        res.payload_length = frame_length_r;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HDR0;
      frame_opcode_r <= 7'd0;
      masked_r       <= 1'b0;
      frame_length_r <= 16'd0;
      mask_key_r     <= 32'd0;
      byte_count_r   <= 16'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      frame_opcode_r <= frame_opcode_nxt;
      masked_r       <= masked_nxt;
      frame_length_r <= frame_length_nxt;
      mask_key_r     <= mask_key_nxt;
      byte_count_r   <= byte_count_nxt;
    end
  end

endmodule

// ===== sv/websocket_frame_deframer_top.sv =====
// WebSocket frame deframer.
// Input channel (in_valid / in_stall / in_rx_byte): one received stream byte
// per item. Output channel (out_valid / out_stall / out_*): zero or one result
// per byte - a payload byte (unmasked), an empty-frame marker, or a rejection
// of a 64-bit length or of a length above the limit. out_last marks the final
// result of a frame.
// Config channel (cfg_valid / cfg_ready / cfg_max_payload): the payload limit,
// always ready; write it only while no bytes are in flight.
// Path: a byte accepted into the input register has its result moved into the
// output register once that register is free. Throughput: one byte per cycle
// while out_stall holds no result; the input and output registers split the
// path, so a byte is taken while a result waits if the input register is empty.
// Stall: when out_stall holds a result and the input register is full,
// in_stall rises in the same cycle; nothing is dropped.
// Reset (synchronous, rst_n low): parser waits for a first header byte, the
// limit returns to 200, both channels are empty.
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [6:0]  out_opcode,
  output logic        out_last,
  output logic [15:0] out_payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload
);
  import wsfd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic [15:0] max_payload_r;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_data_byte_r;
  logic [6:0]  out_opcode_r;
  logic        out_last_r;
  logic [15:0] out_payload_length_r;

  logic        out_free;
  logic        adv;
  result_t     res;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  wsfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .rx_byte     (in_byte_r),
    .max_payload (max_payload_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      max_payload_r <= RESET_LIMIT;
    end else begin
      if (cfg_valid) begin
        max_payload_r <= cfg_max_payload;
      end
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= res.valid;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && res.valid) begin
      out_kind_r           <= res.kind;
      out_data_byte_r      <= res.data_byte;
      out_opcode_r         <= res.opcode;
      out_last_r           <= res.last;
      out_payload_length_r <= res.payload_length;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_data_byte      = out_data_byte_r;
  assign out_opcode         = out_opcode_r;
  assign out_last           = out_last_r;
  assign out_payload_length = out_payload_length_r;

endmodule
